>>> hdl/kmp_pkg.sv
`default_nettype none

package kmp_pkg;

  localparam int MAX_PATTERN = 1024;
  localparam int PAT_AW      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int FAIL_DEPTH  = MAX_PATTERN + 1;
  localparam int MODE_W      = 2;
  localparam int SYM_W       = 8;
  localparam int POS_W       = 20;
  localparam int STEP_W      = 4;

  localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // sequencer steps
  localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] S_DECODE = 4'd1;
  localparam logic [STEP_W-1:0] S_CLEAR  = 4'd2;
  localparam logic [STEP_W-1:0] S_OVF    = 4'd3;
  localparam logic [STEP_W-1:0] S_PFIRST = 4'd4;
  localparam logic [STEP_W-1:0] S_PLOAD  = 4'd5;
  localparam logic [STEP_W-1:0] S_PSEED  = 4'd6;
  localparam logic [STEP_W-1:0] S_WALK   = 4'd7;
  localparam logic [STEP_W-1:0] S_PEND   = 4'd8;
  localparam logic [STEP_W-1:0] S_TPOS   = 4'd9;
  localparam logic [STEP_W-1:0] S_TEND   = 4'd10;
  localparam logic [STEP_W-1:0] S_TFB    = 4'd11;
  localparam logic [STEP_W-1:0] S_EMIT   = 4'd12;

  // datapath actions
  typedef logic [3:0] act_t;
  localparam act_t ACT_NONE   = 4'd0;
  localparam act_t ACT_CLEAR  = 4'd1;
  localparam act_t ACT_OVF    = 4'd2;
  localparam act_t ACT_PFIRST = 4'd3;
  localparam act_t ACT_PWRITE = 4'd4;
  localparam act_t ACT_TPOS   = 4'd5;
  localparam act_t ACT_TCHK   = 4'd6;
  localparam act_t ACT_MLFB   = 4'd7;
  localparam act_t ACT_EMIT   = 4'd8;

  // memory read address source
  typedef logic [1:0] asel_t;
  localparam asel_t A_K     = 2'd0;
  localparam asel_t A_PLEN  = 2'd1;
  localparam asel_t A_FAILQ = 2'd2;
  localparam asel_t A_ML    = 2'd3;

  // match-length register source
  typedef logic [1:0] ksel_t;
  localparam ksel_t K_HOLD  = 2'd0;
  localparam ksel_t K_FAILQ = 2'd1;
  localparam ksel_t K_ML    = 2'd2;
  localparam ksel_t K_WALK  = 2'd3;

  // jump conditions
  typedef logic [2:0] jc_t;
  localparam jc_t JC_NEXT     = 3'd0;
  localparam jc_t JC_JUMP     = 3'd1;
  localparam jc_t JC_ACCEPT   = 3'd2;
  localparam jc_t JC_DISPATCH = 3'd3;
  localparam jc_t JC_WALK     = 3'd4;
  localparam jc_t JC_PLEN0    = 3'd5;
  localparam jc_t JC_MATCH    = 3'd6;
  localparam jc_t JC_OUTFREE  = 3'd7;

  typedef struct packed {
    act_t              act;
    asel_t             asel;
    ksel_t             ksel;
    jc_t               jc;
    logic [STEP_W-1:0] target;
  } ctl_t;

  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t c;
    c = '{act: ACT_NONE, asel: A_K, ksel: K_HOLD, jc: JC_NEXT, target: S_IDLE};
    unique case (step)
      S_IDLE:   c.jc = JC_ACCEPT;
      S_DECODE: c.jc = JC_DISPATCH;
      S_CLEAR:  c = '{act: ACT_CLEAR, asel: A_K, ksel: K_HOLD, jc: JC_JUMP, target: S_EMIT};
      S_OVF:    c = '{act: ACT_OVF, asel: A_K, ksel: K_HOLD, jc: JC_JUMP, target: S_EMIT};
      S_PFIRST: c = '{act: ACT_PFIRST, asel: A_K, ksel: K_HOLD, jc: JC_JUMP, target: S_EMIT};
      S_PLOAD:  c = '{act: ACT_NONE, asel: A_PLEN, ksel: K_HOLD, jc: JC_NEXT, target: S_IDLE};
      S_PSEED:  c = '{act: ACT_NONE, asel: A_FAILQ, ksel: K_FAILQ, jc: JC_NEXT, target: S_IDLE};
      S_WALK:   c = '{act: ACT_NONE, asel: A_FAILQ, ksel: K_WALK, jc: JC_WALK, target: S_TEND};
      S_PEND:   c = '{act: ACT_PWRITE, asel: A_K, ksel: K_HOLD, jc: JC_JUMP, target: S_EMIT};
      S_TPOS:   c = '{act: ACT_TPOS, asel: A_ML, ksel: K_ML, jc: JC_PLEN0, target: S_WALK};
      S_TEND:   c = '{act: ACT_TCHK, asel: A_PLEN, ksel: K_HOLD, jc: JC_MATCH, target: S_EMIT};
      S_TFB:    c = '{act: ACT_MLFB, asel: A_K, ksel: K_HOLD, jc: JC_NEXT, target: S_IDLE};
      S_EMIT:   c = '{act: ACT_EMIT, asel: A_K, ksel: K_HOLD, jc: JC_OUTFREE, target: S_IDLE};
      default:  c = '{act: ACT_NONE, asel: A_K, ksel: K_HOLD, jc: JC_JUMP, target: S_IDLE};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/kmp_stream_matcher_core.sv
`default_nettype none

// Streaming KMP matcher. A clear beat starts a case, pattern beats append one
// byte each while the failure links are extended, and text beats each return
// a match flag with the 1-based start of an occurrence ending there (overlaps
// included). Exactly one result beat per input beat. A small microcode ROM
// sequences one shared datapath around pattern and link memories with one read
// port each; each failure-link hop is one memory read. After accept and decode,
// an ignored pattern byte or unused mode goes straight to emit; clear, overflow,
// first pattern byte or text with an empty pattern take their action step;
// other text takes position, walk and end check, plus a fallback on a match;
// other pattern bytes take load, seed, walk and write. Averaged over a stream,
// the walk takes at most one failure-link hop per symbol. A result waiting in
// the output register holds the sequencer only at its final step.
module kmp_stream_matcher_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [kmp_pkg::MODE_W-1:0]   in_mode,
  input  wire  [kmp_pkg::SYM_W-1:0]    in_symbol,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_match_found,
  output logic [kmp_pkg::POS_W-1:0]    out_match_start,
  output logic                         out_pattern_overflow
);
  import kmp_pkg::*;

  logic [SYM_W-1:0] pat_mem  [MAX_PATTERN];
  logic [LEN_W-1:0] fail_mem [FAIL_DEPTH];

  logic [STEP_W-1:0] upc_r, upc_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic [LEN_W-1:0]  ml_r, ml_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              text_r, text_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [SYM_W-1:0]  sym_r;
  logic              res_found_r, res_found_nxt;
  logic [POS_W-1:0]  res_start_r, res_start_nxt;
  logic              res_ovf_r, res_ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r;
  logic [POS_W-1:0]  out_start_r;
  logic              out_ovf_r;

  logic [SYM_W-1:0]  pat_q;
  logic [LEN_W-1:0]  fail_q;
  logic [LEN_W-1:0]  rd_addr;
  logic              pat_we, fail_we;
  logic [PAT_AW-1:0] pat_wa;
  logic [LEN_W-1:0]  fail_wa, fail_wd;

  ctl_t              cw;
  logic              in_fire, out_free, walk_cont, len_hit;
  logic [LEN_W-1:0]  adv;
  logic [STEP_W-1:0] disp_step;

  assign cw        = ucode(upc_r);
  assign in_ready  = (upc_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign walk_cont = (k_r != '0) && (pat_q != sym_r);
  assign adv       = (pat_q == sym_r) ? (k_r + 1'b1) : '0;
  assign len_hit   = (k_r == plen_r);

  always_comb begin
    unique case (mode_r)
      MODE_CLEAR: disp_step = S_CLEAR;
      MODE_TEXT:  disp_step = S_TPOS;
      MODE_PATTERN: begin
        if (text_r) begin
          disp_step = S_EMIT;
        end else if (plen_r == LEN_W'(MAX_PATTERN)) begin
          disp_step = S_OVF;
        end else if (plen_r == '0) begin
          disp_step = S_PFIRST;
        end else begin
          disp_step = S_PLOAD;
        end
      end
      default:    disp_step = S_EMIT;
    endcase
  end

  always_comb begin
    unique case (cw.jc)
      JC_NEXT:     upc_nxt = upc_r + 1'b1;
      JC_JUMP:     upc_nxt = cw.target;
      JC_ACCEPT:   upc_nxt = in_fire ? (upc_r + 1'b1) : upc_r;
      JC_DISPATCH: upc_nxt = disp_step;
      JC_WALK: begin
        if (walk_cont) begin
          upc_nxt = upc_r;
        end else if (mode_r == MODE_TEXT) begin
          upc_nxt = cw.target;
        end else begin
          upc_nxt = upc_r + 1'b1;
        end
      end
      JC_PLEN0:    upc_nxt = (plen_r == '0) ? S_EMIT : cw.target;
      JC_MATCH:    upc_nxt = len_hit ? (upc_r + 1'b1) : cw.target;
      JC_OUTFREE:  upc_nxt = out_free ? cw.target : upc_r;
      default:     upc_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    case (cw.asel)
      A_PLEN:  rd_addr = plen_r;
      A_FAILQ: rd_addr = fail_q;
      A_ML:    rd_addr = ml_r;
      default: rd_addr = k_r;
    endcase
    case (cw.ksel)
      K_FAILQ: k_nxt = fail_q;
      K_ML:    k_nxt = ml_r;
      K_WALK:  k_nxt = walk_cont ? fail_q : adv;
      default: k_nxt = k_r;
    endcase
  end

  always_comb begin
    plen_nxt      = plen_r;
    ml_nxt        = ml_r;
    pos_nxt       = pos_r;
    text_nxt      = text_r;
    res_found_nxt = res_found_r;
    res_start_nxt = res_start_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pat_we        = 1'b0;
    pat_wa        = plen_r[PAT_AW-1:0];
    fail_we       = 1'b0;
    fail_wa       = plen_r + 1'b1;
    fail_wd       = k_r;
    if (in_fire) begin
      res_found_nxt = 1'b0;
      res_start_nxt = '0;
      res_ovf_nxt   = 1'b0;
    end
    unique case (cw.act)
      ACT_NONE: ;
      ACT_CLEAR: begin
        plen_nxt = '0;
        ml_nxt   = '0;
        pos_nxt  = '0;
        text_nxt = 1'b0;
      end
      ACT_OVF: res_ovf_nxt = 1'b1;
      ACT_PFIRST: begin
        pat_we   = 1'b1;
        pat_wa   = '0;
        fail_we  = 1'b1;
        fail_wa  = LEN_W'(1);
        fail_wd  = '0;
        plen_nxt = LEN_W'(1);
      end
      ACT_PWRITE: begin
        pat_we   = 1'b1;
        fail_we  = 1'b1;
        plen_nxt = plen_r + 1'b1;
      end
      ACT_TPOS: begin
        text_nxt = 1'b1;
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      ACT_TCHK: begin
        if (len_hit) begin
          res_found_nxt = 1'b1;
          res_start_nxt = pos_r - POS_W'(plen_r) + 1'b1;
        end else begin
          ml_nxt = k_r;
        end
      end
      ACT_MLFB: ml_nxt = fail_q;
      ACT_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      plen_r      <= '0;
      ml_r        <= '0;
      pos_r       <= '0;
      text_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      plen_r      <= plen_nxt;
      ml_r        <= ml_nxt;
      pos_r       <= pos_nxt;
      text_r      <= text_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
    res_ovf_r   <= res_ovf_nxt;
    if (in_fire) begin
      mode_r <= in_mode;
      sym_r  <= in_symbol;
    end
    if (cw.act == ACT_EMIT && out_free) begin
      out_found_r <= res_found_r;
      out_start_r <= res_start_r;
      out_ovf_r   <= res_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_wa] <= sym_r;
    end
    if (fail_we) begin
      fail_mem[fail_wa] <= fail_wd;
    end
    pat_q  <= pat_mem[rd_addr[PAT_AW-1:0]];
    fail_q <= fail_mem[rd_addr];
  end

  assign out_valid            = out_valid_r;
  assign out_match_found      = out_found_r;
  assign out_match_start      = out_start_r;
  assign out_pattern_overflow = out_ovf_r;

`ifndef ASSERT_OFF
  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond store");

  a_ml_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == S_IDLE && plen_r != '0) |-> (ml_r < plen_r))
    else $error("matched length not below pattern length");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (upc_r == S_DECODE))
    else $error("accepted beat not decoded");

  a_match_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_start_r != '0 && !out_ovf_r))
    else $error("match result with bad start or overflow");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kmp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_BEATS  = 150;
  localparam int RANDOM_BEATS = 780;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_RUN     = 24;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  sym;
  } sym_beat_t;

  typedef struct {
    logic             found;
    logic [POS_W-1:0] start;
    logic             ovf;
  } match_res_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode;
  logic [SYM_W-1:0]    in_symbol;
  logic                out_valid;
  logic                out_ready;
  logic                out_match_found;
  logic [POS_W-1:0]    out_match_start;
  logic                out_pattern_overflow;

  kmp_stream_matcher_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_symbol            (in_symbol),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_match_found      (out_match_found),
    .out_match_start      (out_match_start),
    .out_pattern_overflow (out_pattern_overflow)
  );

  // matcher state as seen by the predictor
  logic [SYM_W-1:0] pat_mem  [MAX_PATTERN];
  logic [LEN_W-1:0] link_mem [FAIL_DEPTH];
  logic [LEN_W-1:0] pat_len;
  logic [LEN_W-1:0] match_len;
  logic [POS_W-1:0] text_pos;
  logic             text_seen;

  sym_beat_t  beats_to_send [$];
  match_res_t results_due [$];
  sym_beat_t  next_beat;
  match_res_t due_res;
  match_res_t pred_res;
  bit         in_taken;
  int         src_idle;
  int         sink_stall;
  int         cycles;
  int         mismatches;
  int         random_beats;

  function automatic logic [LEN_W-1:0] kmp_extend(input logic [LEN_W-1:0] k,
                                                  input logic [SYM_W-1:0] c);
    logic [LEN_W-1:0] j;
    j = k;
    while (j != '0 && pat_mem[j[PAT_AW-1:0]] != c)
      j = link_mem[j];
    return (pat_mem[j[PAT_AW-1:0]] == c) ? j + 1'b1 : '0;
  endfunction

  function automatic match_res_t kmp_step(input logic [MODE_W-1:0] mode,
                                          input logic [SYM_W-1:0] sym);
    match_res_t       r;
    logic [LEN_W-1:0] k;
    logic [LEN_W-1:0] nxt;
    logic [POS_W-1:0] len_w;
    r.found = 1'b0;
    r.start = '0;
    r.ovf   = 1'b0;
    case (mode)
      MODE_CLEAR: begin
        pat_len   = '0;
        match_len = '0;
        text_pos  = '0;
        text_seen = 1'b0;
      end
      MODE_PATTERN: begin
        if (!text_seen) begin
          if (pat_len >= LEN_W'(MAX_PATTERN)) begin
            r.ovf = 1'b1;
          end else begin
            pat_mem[pat_len[PAT_AW-1:0]] = sym;
            if (pat_len == '0) begin
              link_mem[0] = '0;
              link_mem[1] = '0;
            end else begin
              nxt = pat_len + 1'b1;
              link_mem[nxt] = kmp_extend(link_mem[pat_len], sym);
            end
            pat_len = pat_len + 1'b1;
          end
        end
      end
      MODE_TEXT: begin
        text_seen = 1'b1;
        if (text_pos != POS_MAX)
          text_pos = text_pos + 1'b1;
        if (pat_len != '0) begin
          k = kmp_extend(match_len, sym);
          if (k == pat_len) begin
            len_w   = POS_W'(pat_len);
            r.found = 1'b1;
            r.start = text_pos - len_w + 1'b1;
            k       = link_mem[k];
          end
          match_len = k;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_beat(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] s);
    sym_beat_t b;
    b.mode = m;
    b.sym  = s;
    beats_to_send = {beats_to_send, b};
  endtask

  function automatic logic [SYM_W-1:0] pick_sym(input int base, input int span);
    return SYM_W'(base + $urandom_range(0, span - 1));
  endfunction

  // one case: usually a clear, a pattern over a narrow alphabet (sometimes empty), text with noise and stray beats
  task automatic gen_case();
    int base;
    int span;
    int plen;
    int tlen;
    int r;
    base = $urandom_range(0, 255);
    span = $urandom_range(1, 3);
    if ($urandom_range(0, 9) != 0) begin
      push_beat(MODE_CLEAR, SYM_W'($urandom_range(0, 255)));
      random_beats++;
    end
    r = $urandom_range(0, 19);
    if (r == 0)
      plen = 0;
    else if (r < 3)
      plen = $urandom_range(7, 40);
    else
      plen = $urandom_range(1, 6);
    for (int i = 0; i < plen; i++) begin
      push_beat(MODE_PATTERN, pick_sym(base, span));
      random_beats++;
    end
    tlen = $urandom_range(4, 40);
    for (int i = 0; i < tlen; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        push_beat(MODE_PATTERN, pick_sym(base, span));
      end else if (r == 1) begin
        push_beat(MODE_UNUSED, SYM_W'($urandom_range(0, 255)));
      end else if (r == 2) begin
        push_beat(MODE_TEXT, SYM_W'($urandom_range(0, 255)));
        random_beats++;
      end else begin
        push_beat(MODE_TEXT, pick_sym(base, span));
        random_beats++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    logic [SYM_W-1:0] c;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_mode   = MODE_CLEAR;
    in_symbol = '0;
    out_ready = 1'b0;
    pat_len   = '0;
    match_len = '0;
    text_pos  = '0;
    text_seen = 1'b0;

    // empty pattern, pattern after text, unused mode
    push_beat(MODE_CLEAR, 8'hFF);
    push_beat(MODE_TEXT, 8'h00);
    push_beat(MODE_PATTERN, 8'h41);
    push_beat(MODE_UNUSED, 8'hFF);
    // overlapping occurrences
    push_beat(MODE_CLEAR, 8'h00);
    push_beat(MODE_PATTERN, 8'h00);
    push_beat(MODE_PATTERN, 8'hFF);
    push_beat(MODE_PATTERN, 8'h00);
    push_beat(MODE_TEXT, 8'h00);
    push_beat(MODE_TEXT, 8'hFF);
    push_beat(MODE_TEXT, 8'h00);
    push_beat(MODE_TEXT, 8'hFF);
    push_beat(MODE_TEXT, 8'h00);
    push_beat(MODE_PATTERN, 8'hAA);
    push_beat(MODE_UNUSED, 8'h00);
    // single-symbol pattern
    push_beat(MODE_CLEAR, 8'h5A);
    push_beat(MODE_PATTERN, 8'h61);
    push_beat(MODE_TEXT, 8'h61);
    push_beat(MODE_TEXT, 8'h61);
    push_beat(MODE_TEXT, 8'h62);
    push_beat(MODE_TEXT, 8'h61);
    push_beat(MODE_CLEAR, 8'h00);
    push_beat(MODE_TEXT, 8'h7F);

    // long fallback walks while building the links and while matching
    c = SYM_W'($urandom_range(0, 255));
    push_beat(MODE_CLEAR, 8'h00);
    for (int i = 0; i < LONG_RUN; i++)
      push_beat(MODE_PATTERN, c);
    push_beat(MODE_PATTERN, ~c);
    for (int i = 0; i < LONG_RUN + 6; i++)
      push_beat(MODE_TEXT, c);
    push_beat(MODE_TEXT, ~c);
    for (int i = 0; i < LONG_RUN + 6; i++)
      push_beat(MODE_TEXT, c);

    random_beats = 0;
    while (random_beats < RANDOM_BEATS)
      gen_case();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beats_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (src_idle > 0) begin
          src_idle--;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() > TAIL_BEATS && $urandom_range(0, 7) == 0) begin
          src_idle = $urandom_range(1, 10) - 1;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          next_beat = beats_to_send.pop_front();
          in_valid  <= 1'b1;
          in_mode   <= next_beat.mode;
          in_symbol <= next_beat.sym;
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else if (beats_to_send.size() > TAIL_BEATS && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with no expected result");
          mismatches++;
        end else begin
          due_res = results_due.pop_front();
          if (out_match_found !== due_res.found) begin
            $error("match_found: expected %0d, got %0d", due_res.found, out_match_found);
            mismatches++;
          end
          if (out_match_start !== due_res.start) begin
            $error("match_start: expected %0d, got %0d", due_res.start, out_match_start);
            mismatches++;
          end
          if (out_pattern_overflow !== due_res.ovf) begin
            $error("pattern_overflow: expected %0d, got %0d", due_res.ovf,
                   out_pattern_overflow);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pred_res    = kmp_step(in_mode, in_symbol);
        results_due = {results_due, pred_res};
        in_taken = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/kmp_pkg.sv
hdl/kmp_stream_matcher_core.sv
tb/tb_top.sv
